@@ sv/assert_macros.svh @@
// assertion macros for the lru checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ sv/lru_pkg.sv @@
package lru_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;
    localparam int FIDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W    = FIDX_W;
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int ACT_W     = 4;
    localparam int FAULT_W   = 32;

    localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(FRAMES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } lru_cmd_t;

endpackage

@@ sv/lru_ctrl.sv @@
module lru_ctrl
    import lru_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output lru_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && rsp_stall;
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

@@ sv/lru_dp.sv @@
module lru_dp
    import lru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lru_cmd_t             cmd,
    input  logic                 cfg_wr_en,
    input  logic [ACT_W-1:0]     cfg_wr_data,
    input  logic [PAGE_BITS-1:0] page_number,
    output logic                 hit,
    output logic [FIDX_W-1:0]    frame_index,
    output logic                 evicted_valid,
    output logic [PAGE_BITS-1:0] evicted_page,
    output logic [FAULT_W-1:0]   fault_total
);

    logic [PAGE_BITS-1:0] page_reg;
    logic [ACT_W-1:0]     active_reg;
    logic [PAGE_BITS-1:0] res_page_reg [FRAMES];
    logic [FRAMES-1:0]    valid_reg;
    logic [FRAMES-1:0]    valid_next;
    logic [RANK_W-1:0]    rank_reg     [FRAMES];
    logic [RANK_W-1:0]    rank_next    [FRAMES];
    logic [FAULT_W-1:0]   fault_reg;
    logic [FAULT_W-1:0]   fault_next;

    // lookup results
    logic                 hit_reg;
    logic [FIDX_W-1:0]    hit_idx_reg;
    logic                 empty_reg;
    logic [FIDX_W-1:0]    empty_idx_reg;
    logic [FIDX_W-1:0]    lru_idx_reg;
    logic [CNT_W-1:0]     nvalid_reg;

    logic [CNT_W-1:0]     eff_active;
    logic [FRAMES-1:0]    act_mask;
    logic [FRAMES-1:0]    match_vec;
    logic [FRAMES-1:0]    empty_vec;
    logic                 hit_next;
    logic [FIDX_W-1:0]    hit_idx_next;
    logic                 empty_next;
    logic [FIDX_W-1:0]    empty_idx_next;
    logic [FIDX_W-1:0]    lru_idx_next;
    logic [CNT_W-1:0]     nvalid_next;

    logic [FIDX_W-1:0]    tgt;
    logic [CNT_W-1:0]     old_rank;
    logic                 evict;

    always_comb
    begin
        if (active_reg == '0)
        begin
            eff_active = CNT_W'(1);
        end
        else if (32'(active_reg) > FRAMES)
        begin
            eff_active = CNT_W'(FRAMES);
        end
        else
        begin
            eff_active = CNT_W'(active_reg);
        end
    end

    always_comb
    begin
        hit_idx_next   = '0;
        empty_idx_next = '0;
        lru_idx_next   = '0;
        nvalid_next    = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            act_mask[i]  = CNT_W'(i) < eff_active;
            match_vec[i] = act_mask[i] && valid_reg[i] && (res_page_reg[i] == page_reg);
            empty_vec[i] = act_mask[i] && !valid_reg[i];
            nvalid_next  = nvalid_next + CNT_W'(valid_reg[i]);
        end
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx_next = FIDX_W'(i);
            end
            if (empty_vec[i])
            begin
                empty_idx_next = FIDX_W'(i);
            end
        end
        for (int i = 1; i < FRAMES; i++)
        begin
            if (act_mask[i] && (rank_reg[i] > rank_reg[lru_idx_next]))
            begin
                lru_idx_next = FIDX_W'(i);
            end
        end
        hit_next   = |match_vec;
        empty_next = |empty_vec;
    end

    always_comb
    begin
        priority if (hit_reg)
        begin
            tgt = hit_idx_reg;
        end
        else if (empty_reg)
        begin
            tgt = empty_idx_reg;
        end
        else
        begin
            tgt = lru_idx_reg;
        end
        old_rank = (!hit_reg && empty_reg) ? nvalid_reg : CNT_W'(rank_reg[tgt]);
        evict    = !hit_reg && !empty_reg;

        valid_next = valid_reg;
        valid_next[tgt] = 1'b1;
        for (int i = 0; i < FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (FIDX_W'(i) == tgt)
            begin
                rank_next[i] = '0;
            end
            else if (valid_reg[i] && (CNT_W'(rank_reg[i]) < old_rank))
            begin
                rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
        end

        fault_next = fault_reg;
        if (!hit_reg && (fault_reg != '1))
        begin
            fault_next = fault_reg + FAULT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACT_RESET;
            valid_reg  <= '0;
            fault_reg  <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                active_reg <= cfg_wr_data;
            end
            if (cmd.update)
            begin
                valid_reg <= valid_next;
                fault_reg <= fault_next;
                for (int i = 0; i < FRAMES; i++)
                begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg <= page_number;
        end
        if (cmd.lookup)
        begin
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            empty_reg     <= empty_next;
            empty_idx_reg <= empty_idx_next;
            lru_idx_reg   <= lru_idx_next;
            nvalid_reg    <= nvalid_next;
        end
        if (cmd.update)
        begin
            res_page_reg[tgt] <= page_reg;
            hit               <= hit_reg;
            frame_index       <= tgt;
            evicted_valid     <= evict;
            evicted_page      <= evict ? res_page_reg[tgt] : '0;
            fault_total       <= fault_next;
        end
    end

endmodule

@@ sv/lru_page_replacement_unit.sv @@
// a taken request runs through capture, parallel frame lookup and update, and the response
// is registered at update; a new request is taken only once the last one is updated
// the output register holds a stalled response; the next request is taken meanwhile
// reset: all frames empty, ranks and fault count zero, active_frames = 8
module lru_page_replacement_unit
    import lru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [ACT_W-1:0]     cfg_wr_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [PAGE_BITS-1:0] page_number,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic                 hit,
    output logic [FIDX_W-1:0]    frame_index,
    output logic                 evicted_valid,
    output logic [PAGE_BITS-1:0] evicted_page,
    output logic [FAULT_W-1:0]   fault_total
);

    lru_cmd_t cmd;

    lru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    lru_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .page_number   (page_number),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

endmodule

@@ sv/lru_chk.sv @@
`include "assert_macros.svh"

module lru_chk
    import lru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_stall,
    input  logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  logic                 hit,
    input  logic                 evicted_valid,
    input  logic [PAGE_BITS-1:0] evicted_page,
    input  logic [FAULT_W-1:0]   fault_total
);

    // stalled response beat holds
    `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(fault_total))
    // one request at a time
    `ASSERT_NEXT(a_req_busy, req_valid && !req_stall, req_stall)
    `ASSERT_NOW(a_hit_no_evict, rsp_valid && hit, !evicted_valid)
    `ASSERT_NOW(a_evict_page_zero, rsp_valid && !evicted_valid, evicted_page == '0)
    `ASSERT_NOW(a_fault_counted, rsp_valid && !hit, fault_total != '0)

endmodule

bind lru_page_replacement_unit lru_chk u_lru_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
);
